### hdl/uutp_pkg.sv
package uutp_pkg;

  localparam int unsigned DigitsTotal = 32;
  localparam int unsigned CountW      = 6;
  localparam int unsigned UuidW       = 128;

  localparam logic [7:0] CHAR_OPEN  = 8'h7B;
  localparam logic [7:0] CHAR_CLOSE = 8'h7D;
  localparam logic [7:0] CHAR_DASH  = 8'h2D;

  typedef enum logic [3:0] {
    PH_FIRST      = 4'b0001,
    PH_DIGIT      = 4'b0010,
    PH_AFTER_DASH = 4'b0100,
    PH_DONE       = 4'b1000
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_NO_DASH   = 3'd2,
    ST_BAD_BRACE = 3'd3,
    ST_NON_HEX   = 3'd4
  } status_t;

  typedef struct packed {
    phase_t              phase;
    logic [CountW-1:0]   digit_count;
    logic                brace_mode;
    logic                dash_mode;
    status_t             error_code;
  } parse_ctl_t;

  localparam parse_ctl_t CTL_RESET = '{
    phase:       PH_FIRST,
    digit_count: '0,
    brace_mode:  1'b0,
    dash_mode:   1'b0,
    error_code:  ST_OK
  };

  // bit 4 set: not a hex character
  function automatic logic [4:0] hex_value(input logic [7:0] ch);
    logic [4:0] v;
    case (ch) inside
      [8'h30:8'h39]: v = {1'b0, 4'(ch - 8'h30)};
      [8'h61:8'h66]: v = {1'b0, 4'(ch - 8'h57)};
      [8'h41:8'h46]: v = {1'b0, 4'(ch - 8'h37)};
      default:       v = 5'b1_0000;
    endcase
    return v;
  endfunction

endpackage

### hdl/uutp_step.sv
module uutp_step (
  input  uutp_pkg::parse_ctl_t       ctl_i,
  input  logic [uutp_pkg::UuidW-1:0] bits_i,
  input  logic [7:0]                 char_i,
  output uutp_pkg::parse_ctl_t       ctl_o,
  output logic [uutp_pkg::UuidW-1:0] bits_o
);

  logic [4:0]                  hv;
  logic                        take;
  logic [uutp_pkg::CountW-1:0] dc_inc;
  logic                        at_total;

  assign hv       = uutp_pkg::hex_value(char_i);
  assign dc_inc   = ctl_i.digit_count + uutp_pkg::CountW'(1);
  assign at_total = ctl_i.digit_count >= uutp_pkg::CountW'(uutp_pkg::DigitsTotal);

  always_comb begin
    ctl_o  = ctl_i;
    bits_o = bits_i;
    take   = 1'b0;
    if (ctl_i.error_code == uutp_pkg::ST_OK && ctl_i.phase != uutp_pkg::PH_DONE) begin
      case (ctl_i.phase)
        uutp_pkg::PH_FIRST: begin
          if (char_i == uutp_pkg::CHAR_OPEN) begin
            ctl_o.brace_mode = 1'b1;
            ctl_o.phase      = uutp_pkg::PH_DIGIT;
          end else begin
            take = 1'b1;
          end
        end
        uutp_pkg::PH_AFTER_DASH: take = 1'b1;
        uutp_pkg::PH_DIGIT: begin
          if (at_total) begin
            if (char_i == uutp_pkg::CHAR_CLOSE) ctl_o.phase = uutp_pkg::PH_DONE;
            else ctl_o.error_code = uutp_pkg::ST_BAD_BRACE;
          end else if (ctl_i.digit_count == uutp_pkg::CountW'(8) && !ctl_i.dash_mode &&
                       char_i == uutp_pkg::CHAR_DASH) begin
            ctl_o.dash_mode = 1'b1;
            ctl_o.phase     = uutp_pkg::PH_AFTER_DASH;
          end else if (ctl_i.dash_mode &&
                       (ctl_i.digit_count == uutp_pkg::CountW'(12) ||
                        ctl_i.digit_count == uutp_pkg::CountW'(16) ||
                        ctl_i.digit_count == uutp_pkg::CountW'(20))) begin
            if (char_i == uutp_pkg::CHAR_DASH) ctl_o.phase = uutp_pkg::PH_AFTER_DASH;
            else ctl_o.error_code = uutp_pkg::ST_NO_DASH;
          end else begin
            take = 1'b1;
          end
        end
        default: ;
      endcase
      if (take) begin
        if (hv[4]) begin
          ctl_o.error_code = uutp_pkg::ST_NON_HEX;
        end else begin
          bits_o            = {bits_i[uutp_pkg::UuidW-5:0], hv[3:0]};
          ctl_o.digit_count = dc_inc;
          if (dc_inc >= uutp_pkg::CountW'(uutp_pkg::DigitsTotal) && !ctl_i.brace_mode)
            ctl_o.phase = uutp_pkg::PH_DONE;
          else
            ctl_o.phase = uutp_pkg::PH_DIGIT;
        end
      end
    end
  end

endmodule

### hdl/uuid_text_parser.sv
// UUID text parser.
// Input stream: one ASCII character per transfer on in_tdata, in_tlast on the
// final character of each string. Plain, dashed (8-4-4-4-12) and braced forms
// are taken; characters after a complete UUID are ignored.
// Output stream: one transfer per string, issued for the in_tlast character.
// out_tdata carries the status and the 128-bit value, out_tuser the form flags.
// Status: 0 ok, 1 too short, 2 missing dash, 3 bad close brace, 4 non-hex.
// On any non-zero status the value and flags are zero.
// Latency: the result is valid the cycle after the last character's transfer.
// Throughput: one character per cycle; the parse state update is a single
// decode-and-shift step between the state registers and the output register.
// Stall: the output register holds its result while out_tready is low and
// in_tready drops only while a result is held and not taken.
// Reset (rst_n low, synchronous): parse state returns to expect first character
// and the output register empties.
module uuid_text_parser (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] char_code
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [135:0] out_tdata,  // [2:0] status, [66:3] uuid_high, [130:67] uuid_low
  output logic [1:0]   out_tuser   // [0] had_braces, [1] had_dashes
);

  uutp_pkg::parse_ctl_t       ctl_r, ctl_nxt;
  logic [uutp_pkg::UuidW-1:0] bits_r, bits_nxt;
  logic                       out_valid_r;
  logic [135:0]               out_data_r;
  logic [1:0]                 out_user_r;
  logic                       in_acc;
  uutp_pkg::status_t          status_nxt;

  assign in_tready  = out_tready || !out_valid_r;
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  uutp_step u_step (
    .ctl_i  (ctl_r),
    .bits_i (bits_r),
    .char_i (in_tdata),
    .ctl_o  (ctl_nxt),
    .bits_o (bits_nxt)
  );

  always_comb begin
    if (ctl_nxt.error_code != uutp_pkg::ST_OK) status_nxt = ctl_nxt.error_code;
    else if (ctl_nxt.phase == uutp_pkg::PH_DONE) status_nxt = uutp_pkg::ST_OK;
    else status_nxt = uutp_pkg::ST_SHORT;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= uutp_pkg::CTL_RESET;
    end else if (in_acc) begin
      ctl_r <= in_tlast ? uutp_pkg::CTL_RESET : ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_r <= '0;
    end else if (in_acc) begin
      bits_r <= in_tlast ? '0 : bits_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_tready) begin
      out_valid_r <= in_acc && in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_tlast) begin
      if (status_nxt == uutp_pkg::ST_OK) begin
        out_data_r <= {5'b0, bits_nxt[63:0], bits_nxt[127:64], status_nxt};
        out_user_r <= {ctl_nxt.dash_mode, ctl_nxt.brace_mode};
      end else begin
        out_data_r <= {5'b0, 128'b0, status_nxt};
        out_user_r <= 2'b0;
      end
    end
  end

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> out_tvalid)
    else $error("no result after last character");

  a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tlast && !(out_tvalid && !out_tready) |=> !out_tvalid)
    else $error("result without last character");

  a_error_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2:0] != 3'd0 |-> out_tdata[130:3] == 128'b0 && out_tuser == 2'b0)
    else $error("fields not cleared on error status");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_r.digit_count <= uutp_pkg::CountW'(uutp_pkg::DigitsTotal))
    else $error("digit count beyond 32");

endmodule

### tb/uuid_text_parser_test.sv
`timescale 1ns / 100ps

module uuid_text_parser_test;

  typedef struct {
    logic [7:0] code;
    logic       last;
  } char_item_t;

  typedef struct {
    uutp_pkg::status_t status;
    logic [63:0]       hi;
    logic [63:0]       lo;
    logic              braces;
    logic              dashes;
  } uuid_result_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata = '0;   // [7:0] char_code
  logic         in_tlast = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [135:0] out_tdata;       // [2:0] status, [66:3] uuid_high, [130:67] uuid_low
  logic [1:0]   out_tuser;       // [0] had_braces, [1] had_dashes

  char_item_t   pending_chars[$];
  uuid_result_t expected_uuids[$];
  logic [7:0]   text[$];
  char_item_t   next_char;

  int sent_chars = 0;
  int string_count = 0;
  int results_seen = 0;
  int mismatches = 0;
  int status_seen[5] = '{default: 0};

  // running copy of the parser state
  uutp_pkg::phase_t  trk_phase = uutp_pkg::PH_FIRST;
  logic [5:0]        trk_count = '0;
  logic              trk_brace = 1'b0;
  logic              trk_dash = 1'b0;
  uutp_pkg::status_t trk_err = uutp_pkg::ST_OK;
  logic [63:0]       trk_hi = '0;
  logic [63:0]       trk_lo = '0;

  uuid_text_parser u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
  end

  function automatic logic [4:0] nibble_of(input logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b0, 4'(c - "0")};
    if (c >= "a" && c <= "f") return {1'b0, 4'(c - "a" + 10)};
    if (c >= "A" && c <= "F") return {1'b0, 4'(c - "A" + 10)};
    return 5'h10;
  endfunction

  function automatic logic [7:0] hex_char();
    int v;
    v = $urandom_range(15);
    if (v < 10) return 8'("0" + v);
    if ($urandom_range(1)) return 8'("A" + v - 10);
    return 8'("a" + v - 10);
  endfunction

  task automatic take_digit(input logic [7:0] c);
    logic [4:0] v;
    v = nibble_of(c);
    if (v[4]) begin
      trk_err = uutp_pkg::ST_NON_HEX;
      return;
    end
    trk_hi = {trk_hi[59:0], trk_lo[63:60]};
    trk_lo = {trk_lo[59:0], v[3:0]};
    trk_count = trk_count + 1'b1;
    trk_phase = (trk_count >= uutp_pkg::DigitsTotal && !trk_brace) ?
                uutp_pkg::PH_DONE : uutp_pkg::PH_DIGIT;
  endtask

  task automatic track_uuid_char(input logic [7:0] c, input logic last);
    uuid_result_t r;
    if (trk_err == uutp_pkg::ST_OK && trk_phase != uutp_pkg::PH_DONE) begin
      case (trk_phase)
        uutp_pkg::PH_FIRST: begin
          if (c == uutp_pkg::CHAR_OPEN) begin
            trk_brace = 1'b1;
            trk_phase = uutp_pkg::PH_DIGIT;
          end else begin
            take_digit(c);
          end
        end
        uutp_pkg::PH_AFTER_DASH: begin
          take_digit(c);
        end
        default: begin
          if (trk_count >= uutp_pkg::DigitsTotal) begin
            if (c == uutp_pkg::CHAR_CLOSE) trk_phase = uutp_pkg::PH_DONE;
            else trk_err = uutp_pkg::ST_BAD_BRACE;
          end else if (trk_count == 8 && !trk_dash && c == uutp_pkg::CHAR_DASH) begin
            trk_dash = 1'b1;
            trk_phase = uutp_pkg::PH_AFTER_DASH;
          end else if (trk_dash && (trk_count == 12 || trk_count == 16 || trk_count == 20)) begin
            if (c == uutp_pkg::CHAR_DASH) trk_phase = uutp_pkg::PH_AFTER_DASH;
            else trk_err = uutp_pkg::ST_NO_DASH;
          end else begin
            take_digit(c);
          end
        end
      endcase
    end
    if (last) begin
      if (trk_err != uutp_pkg::ST_OK) r.status = trk_err;
      else if (trk_phase == uutp_pkg::PH_DONE) r.status = uutp_pkg::ST_OK;
      else r.status = uutp_pkg::ST_SHORT;
      if (r.status == uutp_pkg::ST_OK) begin
        r.hi = trk_hi;
        r.lo = trk_lo;
        r.braces = trk_brace;
        r.dashes = trk_dash;
      end else begin
        r.hi = '0;
        r.lo = '0;
        r.braces = 1'b0;
        r.dashes = 1'b0;
      end
      expected_uuids.push_back(r);
      trk_phase = uutp_pkg::PH_FIRST;
      trk_count = '0;
      trk_brace = 1'b0;
      trk_dash = 1'b0;
      trk_err = uutp_pkg::ST_OK;
      trk_hi = '0;
      trk_lo = '0;
    end
  endtask

  task automatic send_text();
    char_item_t it;
    foreach (text[i]) begin
      it.code = text[i];
      it.last = (i == text.size() - 1);
      pending_chars.push_back(it);
    end
    string_count++;
  endtask

  task automatic send_str(input string s);
    text.delete();
    for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
    send_text();
  endtask

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // hold off idling for a stretch in the middle of the run
  function automatic bit calm_phase();
    return sent_chars >= 150 && sent_chars < 260;
  endfunction

  // driver: one character per transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      in_tlast <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        track_uuid_char(in_tdata, in_tlast);
        sent_chars++;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_chars.size() > 0 && (calm_phase() || $urandom_range(99) >= 19)) begin
          next_char = pending_chars.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= next_char.code;
          in_tlast <= next_char.last;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    uuid_result_t e;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (expected_uuids.size() == 0) begin
          report_mismatch($sformatf("unexpected result, tdata %h tuser %b",
                                    out_tdata, out_tuser));
        end else begin
          e = expected_uuids.pop_front();
          status_seen[e.status]++;
          if (out_tdata[2:0] !== e.status)
            report_mismatch($sformatf("status %0d, expected %0d", out_tdata[2:0], e.status));
          if (out_tdata[66:3] !== e.hi)
            report_mismatch($sformatf("uuid_high %h, expected %h", out_tdata[66:3], e.hi));
          if (out_tdata[130:67] !== e.lo)
            report_mismatch($sformatf("uuid_low %h, expected %h", out_tdata[130:67], e.lo));
          if (out_tuser[0] !== e.braces)
            report_mismatch($sformatf("had_braces %b, expected %b", out_tuser[0], e.braces));
          if (out_tuser[1] !== e.dashes)
            report_mismatch($sformatf("had_dashes %b, expected %b", out_tuser[1], e.dashes));
        end
      end
      out_tready <= calm_phase() || $urandom_range(99) >= 19;
    end
  end

  initial begin
    int kind;
    int p;
    bit braces;
    bit dashes;

    // directed: lone characters at the edges, separators in the wrong place
    text = {8'h00};
    send_text();
    text = {8'hFF};
    send_text();
    send_str("{");
    send_str("-");
    send_str("}");
    send_str("g");
    send_str("{{");
    send_str("0-");
    send_str("{-");
    send_str("01234567-");
    send_str("Af09");

    while (pending_chars.size() < 400) begin
      kind = $urandom_range(99);
      text.delete();
      if (kind < 10) begin
        repeat ($urandom_range(1, 5)) text.push_back(8'($urandom_range(255)));
      end else begin
        braces = $urandom_range(1);
        dashes = $urandom_range(1);
        if (braces) text.push_back(uutp_pkg::CHAR_OPEN);
        for (int d = 0; d < uutp_pkg::DigitsTotal; d++) begin
          if (dashes && (d == 8 || d == 12 || d == 16 || d == 20))
            text.push_back(uutp_pkg::CHAR_DASH);
          text.push_back(hex_char());
        end
        if (braces) text.push_back(uutp_pkg::CHAR_CLOSE);
        if (kind >= 55) begin
          p = $urandom_range(text.size() - 1);
          case ($urandom_range(4))
            0: while (text.size() > p + 1) void'(text.pop_back());
            1: text[p] = 8'($urandom_range(255));
            2: if (text.size() > 1) text.delete(p);
            3: text.insert(p, ($urandom_range(1) ? uutp_pkg::CHAR_DASH : hex_char()));
            default: text[text.size() - 1] = 8'($urandom_range(255));
          endcase
        end
        if ($urandom_range(3) == 0)
          repeat ($urandom_range(1, 3)) text.push_back(8'($urandom_range(255)));
      end
      send_text();
    end

    while (!rst_n || pending_chars.size() > 0 || in_tvalid) @(posedge clk);
    while (expected_uuids.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d strings in %0d characters; checked %0d results", string_count,
             sent_chars, results_seen);
    $display("Status mix: ok %0d, short %0d, no dash %0d, bad brace %0d, non-hex %0d",
             status_seen[uutp_pkg::ST_OK], status_seen[uutp_pkg::ST_SHORT],
             status_seen[uutp_pkg::ST_NO_DASH], status_seen[uutp_pkg::ST_BAD_BRACE],
             status_seen[uutp_pkg::ST_NON_HEX]);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timeout waiting for results");
    $display("Test completed with failures");
    $finish;
  end

endmodule
